[src/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg
// shared constants, field widths and the result bundle of the text console
// ----------------------------------------------------------------------------
package tcw_pkg;

	// default screen geometry
	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	// fixed field widths
	localparam int OP_W        = 1;
	localparam int CHAR_W      = 8;
	localparam int COLOR_W     = 8;
	localparam int INDEX_W     = 11;
	localparam int POS_W       = 11;
	localparam int CELL_DATA_W = 16;

	// item codes
	localparam logic [OP_W-1:0] OP_WRITE = 1'b0;
	localparam logic [OP_W-1:0] OP_READ  = 1'b1;

	// character and cell constants
	localparam logic [CHAR_W-1:0]      NEWLINE_CODE     = 8'd10;
	localparam logic [CHAR_W-1:0]      SPACE_CODE       = 8'd32;
	localparam logic [CELL_DATA_W-1:0] BLANK_CELL       = 16'h0720;
	localparam logic [COLOR_W-1:0]     TEXT_COLOR_RESET = 8'd7;

	// finished result handed from the sequencer to the output register
	typedef struct packed {
		logic                   valid;
		logic [POS_W-1:0]       cursor_pos;
		logic [CELL_DATA_W-1:0] cell_data;
		logic                   scrolled;
	} tcw_res_t;

endpackage

[src/tcw_screen_ram.sv]
// ----------------------------------------------------------------------------
// tcw_screen_ram
// single-port screen memory, one access a cycle, registered read data
// ----------------------------------------------------------------------------
module tcw_screen_ram #(
	parameter int DEPTH  = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic                             re,
	input  logic [ADDR_W-1:0]                addr,
	input  logic [tcw_pkg::CELL_DATA_W-1:0]  wdata,
	output logic [tcw_pkg::CELL_DATA_W-1:0]  rdata
);

	logic [tcw_pkg::CELL_DATA_W-1:0] mem [DEPTH];
	logic [tcw_pkg::CELL_DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

[src/tcw_addr_unit.sv]
// ----------------------------------------------------------------------------
// tcw_addr_unit
// shared adder: offset plus ring base, folded back into the cell range
// ----------------------------------------------------------------------------
module tcw_addr_unit #(
	parameter int DEPTH  = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic [ADDR_W-1:0] offset,
	input  logic [ADDR_W-1:0] base,
	output logic [ADDR_W-1:0] sum
);

	localparam logic [ADDR_W:0] DEPTH_X = (ADDR_W+1)'(DEPTH);

	logic [ADDR_W:0] raw;

	always_comb begin
		raw = {1'b0, offset} + {1'b0, base};
		if (raw >= DEPTH_X) begin
			raw = raw - DEPTH_X;
		end
		sum = raw[ADDR_W-1:0];
	end

endmodule

[src/tcw_ctrl.sv]
// ----------------------------------------------------------------------------
// tcw_ctrl
// sequencer: cursor, ring base, color register, clearing and scroll sweeps
// ----------------------------------------------------------------------------
module tcw_ctrl #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF,
	parameter int AW      = $clog2(COLUMNS * ROWS)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [tcw_pkg::OP_W-1:0]         op,
	input  logic [tcw_pkg::CHAR_W-1:0]       char_code,
	input  logic [tcw_pkg::INDEX_W-1:0]      read_index,
	input  logic                             cfg_wr_en,
	input  logic [tcw_pkg::COLOR_W-1:0]      cfg_wr_data,
	input  logic                             out_free,
	output tcw_pkg::tcw_res_t                res,
	output logic                             ram_we,
	output logic                             ram_re,
	output logic [AW-1:0]                    ram_addr,
	output logic [tcw_pkg::CELL_DATA_W-1:0]  ram_wdata,
	input  logic [tcw_pkg::CELL_DATA_W-1:0]  ram_rdata,
	output logic [AW-1:0]                    unit_offset,
	output logic [AW-1:0]                    unit_base,
	input  logic [AW-1:0]                    unit_sum
);

	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int COL_W      = $clog2(COLUMNS);
	localparam logic [AW-1:0]    LAST_ROW_START = AW'((ROWS - 1) * COLUMNS);
	localparam logic [AW-1:0]    COLUMNS_A      = AW'(COLUMNS);
	localparam logic [AW-1:0]    LAST_CELL      = AW'(CELL_COUNT - 1);
	localparam logic [AW-1:0]    LAST_COL_A     = AW'(COLUMNS - 1);
	localparam logic [COL_W-1:0] LAST_COL       = COL_W'(COLUMNS - 1);

	typedef enum logic [6:0] {
		S_INIT      = 7'b0000001,
		S_IDLE      = 7'b0000010,
		S_EXEC      = 7'b0000100,
		S_READ      = 7'b0001000,
		S_CLEAR_ROW = 7'b0010000,
		S_ROTATE    = 7'b0100000,
		S_DONE      = 7'b1000000
	} tcw_state_t;

	tcw_state_t                       state_q;
	logic [tcw_pkg::OP_W-1:0]         op_q;
	logic [tcw_pkg::CHAR_W-1:0]       char_q;
	logic [tcw_pkg::INDEX_W-1:0]      index_q;
	logic [tcw_pkg::COLOR_W-1:0]      color_q;
	logic [COL_W-1:0]                 col_q;
	logic [AW-1:0]                    row_start_q;
	logic [AW-1:0]                    pos_q;
	logic [AW-1:0]                    base_q;
	logic [AW-1:0]                    sweep_q;
	logic [tcw_pkg::CELL_DATA_W-1:0]  cell_q;
	logic                             scrolled_q;
	logic                             index_ok;
	logic                             is_read;
	logic                             is_newline;

	assign in_stall   = (state_q != S_IDLE);
	assign index_ok   = (32'(index_q) < 32'(CELL_COUNT));
	assign is_read    = (op_q == tcw_pkg::OP_READ);
	assign is_newline = (char_q == tcw_pkg::NEWLINE_CODE);

	// operand selection for the shared adder
	always_comb begin
		unit_base = base_q;
		case (state_q)
			S_EXEC:   unit_offset = is_read ? AW'(index_q) : pos_q;
			S_ROTATE: unit_offset = COLUMNS_A;
			default:  unit_offset = sweep_q;
		endcase
	end

	always_comb begin
		ram_addr  = unit_sum;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_wdata = tcw_pkg::BLANK_CELL;
		case (state_q)
			S_INIT: begin
				ram_we = 1'b1;
			end
			S_EXEC: begin
				ram_re    = is_read && index_ok;
				ram_we    = !is_read && !is_newline;
				ram_wdata = {color_q, char_q};
			end
			S_CLEAR_ROW: begin
				ram_we    = 1'b1;
				ram_wdata = {color_q, tcw_pkg::SPACE_CODE};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	assign res.valid      = (state_q == S_DONE) && out_free;
	assign res.cursor_pos = tcw_pkg::POS_W'(pos_q);
	assign res.cell_data  = cell_q;
	assign res.scrolled   = scrolled_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= tcw_pkg::TEXT_COLOR_RESET;
		end else if (cfg_wr_en) begin
			color_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE) begin
			op_q    <= op;
			char_q  <= char_code;
			index_q <= read_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			col_q       <= '0;
			row_start_q <= '0;
			pos_q       <= '0;
			base_q      <= '0;
			sweep_q     <= '0;
			cell_q      <= '0;
			scrolled_q  <= 1'b0;
		end else begin
			case (state_q)
				S_INIT: begin
					sweep_q <= sweep_q + AW'(1);
					if (sweep_q == LAST_CELL) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					cell_q     <= '0;
					scrolled_q <= 1'b0;
					sweep_q    <= '0;
					if (is_read) begin
						state_q <= index_ok ? S_READ : S_DONE;
					end else if (!is_newline && (col_q != LAST_COL)) begin
						col_q   <= col_q + COL_W'(1);
						pos_q   <= pos_q + AW'(1);
						state_q <= S_DONE;
					end else begin
						// line feed, from a newline or from running off the row
						col_q <= '0;
						if (row_start_q == LAST_ROW_START) begin
							pos_q      <= LAST_ROW_START;
							scrolled_q <= 1'b1;
							state_q    <= S_CLEAR_ROW;
						end else begin
							row_start_q <= row_start_q + COLUMNS_A;
							pos_q       <= row_start_q + COLUMNS_A;
							state_q     <= S_DONE;
						end
					end
				end
				S_READ: begin
					cell_q  <= ram_rdata;
					state_q <= S_DONE;
				end
				S_CLEAR_ROW: begin
					sweep_q <= sweep_q + AW'(1);
					if (sweep_q == LAST_COL_A) begin
						state_q <= S_ROTATE;
					end
				end
				S_ROTATE: begin
					base_q  <= unit_sum;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[src/text_console_writer.sv]
// ----------------------------------------------------------------------------
// text_console_writer
// text console engine: cursor, character store, cell read and ring scroll
// ----------------------------------------------------------------------------
//
//   channel  | beat handshake               | payload
//   ---------+------------------------------+--------------------------------
//   in       | in_valid / in_stall          | op, char_code, read_index
//   out      | out_valid / out_stall        | cursor_pos, cell_data, scrolled
//   config   | cfg_wr_en (no wait)          | cfg_wr_data (text color)
//
// counted from one input accept to the earliest next one, a plain write or
// newline passes EXEC and DONE, a read in range adds READ, and a scrolling
// write adds CLEAR_ROW and ROTATE: the shared adder sweeps one cell of the
// blank bottom row per cycle through the single memory port. out_valid rises
// as in_stall drops for that next accept. after reset the block clears the
// whole screen with in_stall high; config writes are taken during that pass.
// a result waits in the output register while the next beat is worked on;
// a second result holds the sequencer until out_stall drops.
//
module text_console_writer #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// input items
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [tcw_pkg::OP_W-1:0]         op,
	input  logic [tcw_pkg::CHAR_W-1:0]       char_code,
	input  logic [tcw_pkg::INDEX_W-1:0]      read_index,
	// results
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [tcw_pkg::POS_W-1:0]        cursor_pos,
	output logic [tcw_pkg::CELL_DATA_W-1:0]  cell_data,
	output logic                             scrolled,
	// text color register
	input  logic                             cfg_wr_en,
	input  logic [tcw_pkg::COLOR_W-1:0]      cfg_wr_data
);

	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int AW         = $clog2(CELL_COUNT);

	tcw_pkg::tcw_res_t               res;
	logic                            out_free;
	logic                            ram_we;
	logic                            ram_re;
	logic [AW-1:0]                   ram_addr;
	logic [tcw_pkg::CELL_DATA_W-1:0] ram_wdata;
	logic [tcw_pkg::CELL_DATA_W-1:0] ram_rdata;
	logic [AW-1:0]                   unit_offset;
	logic [AW-1:0]                   unit_base;
	logic [AW-1:0]                   unit_sum;

	// output register state
	logic                            out_valid_q;
	logic [tcw_pkg::POS_W-1:0]       cursor_pos_q;
	logic [tcw_pkg::CELL_DATA_W-1:0] cell_data_q;
	logic                            scrolled_q;

	// sequencer: owns cursor, ring base (top screen row in memory) and color
	tcw_ctrl #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS),
		.AW      (AW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.char_code   (char_code),
		.read_index  (read_index),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.out_free    (out_free),
		.res         (res),
		.ram_we      (ram_we),
		.ram_re      (ram_re),
		.ram_addr    (ram_addr),
		.ram_wdata   (ram_wdata),
		.ram_rdata   (ram_rdata),
		.unit_offset (unit_offset),
		.unit_base   (unit_base),
		.unit_sum    (unit_sum)
	);

	// the one adder: logical cell offset to physical address, and base advance
	tcw_addr_unit #(
		.DEPTH  (CELL_COUNT),
		.ADDR_W (AW)
	) u_addr (
		.offset (unit_offset),
		.base   (unit_base),
		.sum    (unit_sum)
	);

	// screen cells, rows kept as a ring so a scroll moves nothing
	tcw_screen_ram #(
		.DEPTH  (CELL_COUNT),
		.ADDR_W (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// output register frees the sequencer while a result waits downstream
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload only, no reset needed
	always_ff @(posedge clk) begin
		if (res.valid) begin
			cursor_pos_q <= res.cursor_pos;
			cell_data_q  <= res.cell_data;
			scrolled_q   <= res.scrolled;
		end
	end

	assign out_valid  = out_valid_q;
	assign cursor_pos = cursor_pos_q;
	assign cell_data  = cell_data_q;
	assign scrolled   = scrolled_q;

	// a new result never overwrites one that is still stalled
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> out_free)
		else $error("result loaded over a stalled beat");

	// one item at a time: an accepted beat stalls the input next cycle
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input accepted twice in a row");

	// a scroll always leaves the cursor at the start of the bottom row
	a_scroll_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.scrolled) |->
			(res.cursor_pos == tcw_pkg::POS_W'((ROWS - 1) * COLUMNS)))
		else $error("scroll left cursor off the bottom row start");

endmodule
